### rtl/spc_pkg.sv
// ----------------------------------------------------------------------------
// spc_pkg: shared definitions for the segment/polyhedron clipper
// Widths, request kind codes, fixed-point constants and state encodings
// used by the channel interfaces, the serial divider and the top level.
// ----------------------------------------------------------------------------
`default_nettype none

package spc_pkg;

   // Field and arithmetic geometry
   localparam int COORD_BITS  = 32;
   localparam int T_FRAC_BITS = 30;
   localparam int COORD_FRAC  = 16;
   localparam int FIELD_W     = 32;
   localparam int KIND_W      = 2;
   localparam int T_W         = 32;

   localparam int IN_BITS  = (COORD_BITS < FIELD_W) ? COORD_BITS : FIELD_W;
   localparam int DIR_W    = IN_BITS + 1;
   localparam int ACC_W    = 2 * IN_BITS + 4;
   localparam int AXES     = 3;
   localparam int AXIS_W   = 2;
   localparam int BIT_W    = $clog2(IN_BITS);
   localparam int Q_BITS   = T_W - 1;
   localparam int CNT_W    = $clog2(Q_BITS);

   localparam logic [BIT_W-1:0]  BIT_LAST  = BIT_W'(IN_BITS - 1);
   localparam logic [AXIS_W-1:0] AXIS_LAST = AXIS_W'(AXES - 1);
   localparam logic [CNT_W-1:0]  CNT_LAST  = CNT_W'(Q_BITS - 1);

   // Request kinds; the remaining code is a no-op
   localparam logic [KIND_W-1:0] KIND_START = 2'd0;
   localparam logic [KIND_W-1:0] KIND_END   = 2'd1;
   localparam logic [KIND_W-1:0] KIND_PLANE = 2'd2;

   // t constants
   localparam logic signed [T_W-1:0] T_ONE =
      {{(T_W - 1 - T_FRAC_BITS){1'b0}}, 1'b1, {T_FRAC_BITS{1'b0}}};
   localparam logic signed [T_W-1:0] T_MAX = {1'b0, {Q_BITS{1'b1}}};
   localparam logic signed [T_W-1:0] T_MIN = {1'b1, {Q_BITS{1'b0}}};

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_MAC,
      ST_TEST,
      ST_WAIT,
      ST_EMIT
   } top_state_type;

   typedef enum logic [1:0] {
      DV_IDLE,
      DV_CHECK,
      DV_RUN,
      DV_DONE
   } div_state_type;

endpackage

`default_nettype wire

### rtl/spc_channels.sv
// ----------------------------------------------------------------------------
// spc_channels: request and response channel interfaces
// Valid/ready channels; an item moves on a clock edge with valid and ready high.
// ----------------------------------------------------------------------------
`default_nettype none

interface spc_req_if import spc_pkg::*; ();
   logic                      valid;
   logic                      ready;
   logic [KIND_W-1:0]         kind;
   logic signed [FIELD_W-1:0] x;
   logic signed [FIELD_W-1:0] y;
   logic signed [FIELD_W-1:0] z;
   logic signed [FIELD_W-1:0] offset;
   logic                      last;

   modport source (output valid, kind, x, y, z, offset, last, input ready);
   modport sink   (input valid, kind, x, y, z, offset, last, output ready);
endinterface

interface spc_rsp_if import spc_pkg::*; ();
   logic                  valid;
   logic                  ready;
   logic                  hit;
   logic signed [T_W-1:0] t_first;
   logic signed [T_W-1:0] t_last;

   modport source (output valid, hit, t_first, t_last, input ready);
   modport sink   (input valid, hit, t_first, t_last, output ready);
endinterface

`default_nettype wire

### rtl/spc_div.sv
// ----------------------------------------------------------------------------
// spc_div: serial signed divider for the clip parameter
// Restoring radix-2 division, one quotient bit per cycle, result saturated.
// ----------------------------------------------------------------------------
`default_nettype none

module spc_div import spc_pkg::*; (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    start,
   input  wire logic signed [ACC_W-1:0] num,
   input  wire logic signed [ACC_W-1:0] den,
   output logic                         done,
   output logic signed [T_W-1:0]        quot
);

   localparam int DVD_W = ACC_W + T_FRAC_BITS;

   div_state_type state_ff, state_in;

   logic [ACC_W-1:0]  rem_ff;
   logic [ACC_W-1:0]  den_ff;
   logic [Q_BITS-1:0] dv_ff;
   logic [Q_BITS-1:0] q_ff;
   logic [CNT_W-1:0]  cnt_ff;
   logic              neg_ff;
   logic              ovf_ff;

   logic [ACC_W-1:0]  num_abs;
   logic [ACC_W-1:0]  den_abs;
   logic [DVD_W-1:0]  dvd_wide;
   logic [ACC_W:0]    trial;
   logic [ACC_W:0]    diff;
   logic              fits;
   logic signed [T_W-1:0] q_ext;

   assign num_abs  = num[ACC_W-1] ? -num : num;
   assign den_abs  = den[ACC_W-1] ? -den : den;
   assign dvd_wide = {num_abs, {T_FRAC_BITS{1'b0}}};

   // shift in the next dividend bit, trial-subtract the divisor
   assign trial = {rem_ff, dv_ff[Q_BITS-1]};
   assign diff  = trial - {1'b0, den_ff};
   assign fits  = (trial >= {1'b0, den_ff});

   assign q_ext = $signed({1'b0, q_ff});
   assign quot  = ovf_ff ? (neg_ff ? T_MIN : T_MAX) : (neg_ff ? -q_ext : q_ext);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= DV_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      done     = 1'b0;
      case (state_ff)
         DV_IDLE: begin
            if (start) state_in = DV_CHECK;
         end
         DV_CHECK: begin
            state_in = (rem_ff >= den_ff) ? DV_DONE : DV_RUN;
         end
         DV_RUN: begin
            if (cnt_ff == CNT_LAST) state_in = DV_DONE;
         end
         DV_DONE: begin
            done     = 1'b1;
            state_in = DV_IDLE;
         end
         default: state_in = DV_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      case (state_ff)
         DV_IDLE: begin
            if (start) begin
               neg_ff <= num[ACC_W-1] ^ den[ACC_W-1];
               den_ff <= den_abs;
               rem_ff <= num_abs >> (Q_BITS - T_FRAC_BITS);
               dv_ff  <= dvd_wide[Q_BITS-1:0];
               q_ff   <= '0;
               cnt_ff <= '0;
            end
         end
         DV_CHECK: begin
            ovf_ff <= (rem_ff >= den_ff);
         end
         DV_RUN: begin
            rem_ff <= fits ? diff[ACC_W-1:0] : trial[ACC_W-1:0];
            dv_ff  <= {dv_ff[Q_BITS-2:0], 1'b0};
            q_ff   <= {q_ff[Q_BITS-2:0], fits};
            cnt_ff <= cnt_ff + 1'b1;
         end
         default: begin
         end
      endcase
   end

   // the partial remainder stays below the divisor once past the range check
   a_rem_below_den: assert property (@(posedge clock) disable iff (reset)
      state_ff == DV_RUN |-> rem_ff < den_ff)
      else $error("divider remainder not below divisor");

   a_start_when_idle: assert property (@(posedge clock) disable iff (reset)
      start |-> state_ff == DV_IDLE)
      else $error("divider started while busy");

   a_den_nonzero: assert property (@(posedge clock) disable iff (reset)
      state_ff == DV_CHECK |-> den_ff != '0)
      else $error("divider loaded with zero divisor");

endmodule

`default_nettype wire

### rtl/segment_polyhedron_clip.sv
// ----------------------------------------------------------------------------
// segment_polyhedron_clip: clip a 3D segment against a convex polyhedron
// Cyrus-Beck interval clipping with bit-serial dot products and a serial
// divider; reports hit and the entry/exit parameters on the last request.
// ----------------------------------------------------------------------------
//
//   channel  direction  handshake     payload
//   req_ch   in         valid/ready   kind, x, y, z, offset, last
//   rsp_ch   out        valid/ready   hit, t_first, t_last
//
// Start/end points, no-ops and planes of an empty query are handled while idle.
// A plane runs bit-serial multiply-accumulate over the three axes (one normal
// bit per cycle), a test state, then the divider (range check, quotient bits,
// done). A parallel plane skips the divider; when the quotient saturates, the
// divider goes from the range check straight to done. No new request is taken
// until the plane is through. A request with last then passes the emit state
// to load the response register. Synchronous reset sets the interval to [0,1]
// and clears the segment, the empty flag and the response. A stalled response
// holds in its register; new requests are taken while it waits.
// ----------------------------------------------------------------------------
`default_nettype none

module segment_polyhedron_clip import spc_pkg::*; (
   input  wire logic   clock,
   input  wire logic   reset,
   spc_req_if.sink     req_ch,
   spc_rsp_if.source   rsp_ch
);

   localparam int NSH_W = AXES * IN_BITS;

   top_state_type state_ff, state_in;

   // query state
   logic signed [IN_BITS-1:0] seg_start_ff [AXES];
   logic signed [DIR_W-1:0]   seg_dir_ff   [AXES];
   logic signed [T_W-1:0]     t_enter_ff;
   logic signed [T_W-1:0]     t_exit_ff;
   logic                      query_empty_ff;
   logic                      last_ff;

   // multiply-accumulate datapath
   logic [NSH_W-1:0]          nsh_ff;
   logic [BIT_W-1:0]          bit_ff;
   logic [AXIS_W-1:0]         axis_ff;
   logic [AXIS_W-1:0]         axis_next;
   logic signed [ACC_W-1:0]   mden_ff;
   logic signed [ACC_W-1:0]   mdist_ff;
   logic signed [ACC_W-1:0]   acc_den_ff;
   logic signed [ACC_W-1:0]   acc_dist_ff;
   logic signed [ACC_W-1:0]   acc_den_in;
   logic signed [ACC_W-1:0]   acc_dist_in;
   logic signed [ACC_W-1:0]   off_ext;

   // response register
   logic                      rsp_valid_ff;
   logic                      hit_ff;
   logic signed [T_W-1:0]     t_first_ff;
   logic signed [T_W-1:0]     t_last_ff;

   // control
   logic                      req_ready;
   logic                      req_fire;
   logic                      div_start;
   logic                      div_done;
   logic signed [T_W-1:0]     div_quot;
   logic                      emit_load;

   // interval update from a finished quotient
   logic signed [T_W-1:0]     enter_new;
   logic signed [T_W-1:0]     exit_new;

   assign req_ch.ready = req_ready;
   assign req_fire     = req_ch.valid && req_ready;

   assign rsp_ch.valid   = rsp_valid_ff;
   assign rsp_ch.hit     = hit_ff;
   assign rsp_ch.t_first = t_first_ff;
   assign rsp_ch.t_last  = t_last_ff;

   assign off_ext = ACC_W'($signed(req_ch.offset[IN_BITS-1:0]));

   // ------------------------------------------------------------------------
   // Divider
   // ------------------------------------------------------------------------
   spc_div u_div (
      .clock (clock),
      .reset (reset),
      .start (div_start),
      .num   (acc_dist_ff),
      .den   (acc_den_ff),
      .done  (div_done),
      .quot  (div_quot)
   );

   // ------------------------------------------------------------------------
   // State machine
   // ------------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      req_ready = 1'b0;
      div_start = 1'b0;
      emit_load = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_ch.valid) begin
               if (req_ch.kind == KIND_PLANE && !query_empty_ff) begin
                  state_in = ST_MAC;
               end else if (req_ch.last) begin
                  state_in = ST_EMIT;
               end
            end
         end
         ST_MAC: begin
            if (bit_ff == BIT_LAST && axis_ff == AXIS_LAST) state_in = ST_TEST;
         end
         ST_TEST: begin
            // parallel plane: no division, only the side test
            if (acc_den_ff == '0) begin
               state_in = last_ff ? ST_EMIT : ST_IDLE;
            end else begin
               div_start = 1'b1;
               state_in  = ST_WAIT;
            end
         end
         ST_WAIT: begin
            if (div_done) state_in = last_ff ? ST_EMIT : ST_IDLE;
         end
         ST_EMIT: begin
            if (!rsp_valid_ff || rsp_ch.ready) begin
               emit_load = 1'b1;
               state_in  = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // ------------------------------------------------------------------------
   // Bit-serial dot products: denom = n.dir, dist = d - n.start
   // Two's complement normal: the sign bit weighs negative.
   // ------------------------------------------------------------------------
   always_comb begin
      acc_den_in  = acc_den_ff;
      acc_dist_in = acc_dist_ff;
      if (nsh_ff[0]) begin
         if (bit_ff == BIT_LAST) begin
            acc_den_in  = acc_den_ff - mden_ff;
            acc_dist_in = acc_dist_ff + mdist_ff;
         end else begin
            acc_den_in  = acc_den_ff + mden_ff;
            acc_dist_in = acc_dist_ff - mdist_ff;
         end
      end
   end

   assign axis_next = (axis_ff == AXIS_LAST) ? '0 : axis_ff + 1'b1;

   always_ff @(posedge clock) begin
      if (req_fire && req_ch.kind == KIND_PLANE) begin
         nsh_ff      <= {req_ch.z[IN_BITS-1:0], req_ch.y[IN_BITS-1:0],
                         req_ch.x[IN_BITS-1:0]};
         acc_den_ff  <= '0;
         acc_dist_ff <= off_ext <<< COORD_FRAC;
         mden_ff     <= ACC_W'(seg_dir_ff[0]);
         mdist_ff    <= ACC_W'(seg_start_ff[0]);
      end else if (state_ff == ST_MAC) begin
         acc_den_ff  <= acc_den_in;
         acc_dist_ff <= acc_dist_in;
         nsh_ff      <= nsh_ff >> 1;
         if (bit_ff == BIT_LAST) begin
            // advance to the next axis: reload the multiplicands
            mden_ff  <= ACC_W'(seg_dir_ff[axis_next]);
            mdist_ff <= ACC_W'(seg_start_ff[axis_next]);
         end else begin
            mden_ff  <= mden_ff <<< 1;
            mdist_ff <= mdist_ff <<< 1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         bit_ff  <= '0;
         axis_ff <= '0;
      end else if (req_fire) begin
         bit_ff  <= '0;
         axis_ff <= '0;
      end else if (state_ff == ST_MAC) begin
         if (bit_ff == BIT_LAST) begin
            bit_ff  <= '0;
            axis_ff <= axis_next;
         end else begin
            bit_ff <= bit_ff + 1'b1;
         end
      end
   end

   // ------------------------------------------------------------------------
   // Interval update: negative denom raises the entry, positive lowers the exit
   // ------------------------------------------------------------------------
   always_comb begin
      enter_new = t_enter_ff;
      exit_new  = t_exit_ff;
      if (acc_den_ff[ACC_W-1]) begin
         if (div_quot > t_enter_ff) enter_new = div_quot;
      end else begin
         if (div_quot < t_exit_ff) exit_new = div_quot;
      end
   end

   // ------------------------------------------------------------------------
   // Query state
   // ------------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < AXES; i++) begin
            seg_start_ff[i] <= '0;
            seg_dir_ff[i]   <= '0;
         end
         t_enter_ff     <= '0;
         t_exit_ff      <= T_ONE;
         query_empty_ff <= 1'b0;
      end else begin
         case (state_ff)
            ST_IDLE: begin
               if (req_fire) begin
                  case (req_ch.kind)
                     KIND_START: begin
                        seg_start_ff[0] <= req_ch.x[IN_BITS-1:0];
                        seg_start_ff[1] <= req_ch.y[IN_BITS-1:0];
                        seg_start_ff[2] <= req_ch.z[IN_BITS-1:0];
                        for (int i = 0; i < AXES; i++) seg_dir_ff[i] <= '0;
                        t_enter_ff     <= '0;
                        t_exit_ff      <= T_ONE;
                        query_empty_ff <= 1'b0;
                     end
                     KIND_END: begin
                        seg_dir_ff[0] <= DIR_W'($signed(req_ch.x[IN_BITS-1:0]))
                                         - DIR_W'(seg_start_ff[0]);
                        seg_dir_ff[1] <= DIR_W'($signed(req_ch.y[IN_BITS-1:0]))
                                         - DIR_W'(seg_start_ff[1]);
                        seg_dir_ff[2] <= DIR_W'($signed(req_ch.z[IN_BITS-1:0]))
                                         - DIR_W'(seg_start_ff[2]);
                     end
                     default: begin
                     end
                  endcase
               end
            end
            ST_TEST: begin
               // parallel plane with the start point outside: drop the query
               if (acc_den_ff == '0 && !acc_dist_ff[ACC_W-1] && acc_dist_ff != '0) begin
                  query_empty_ff <= 1'b1;
               end
            end
            ST_WAIT: begin
               if (div_done) begin
                  t_enter_ff <= enter_new;
                  t_exit_ff  <= exit_new;
                  if (enter_new > exit_new) query_empty_ff <= 1'b1;
               end
            end
            default: begin
            end
         endcase
      end
   end

   // hold the last flag for the plane's result
   always_ff @(posedge clock) begin
      if (req_fire) last_ff <= req_ch.last;
   end

   // ------------------------------------------------------------------------
   // Response register
   // ------------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (emit_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ch.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (emit_load) begin
         hit_ff     <= !query_empty_ff;
         t_first_ff <= t_enter_ff;
         t_last_ff  <= t_exit_ff;
      end
   end

   // ------------------------------------------------------------------------
   // Assertions
   // ------------------------------------------------------------------------
   a_interval_ordered: assert property (@(posedge clock) disable iff (reset)
      !query_empty_ff |-> t_enter_ff <= t_exit_ff)
      else $error("live query with inverted interval");

   a_empty_sticky: assert property (@(posedge clock) disable iff (reset)
      query_empty_ff && !(req_fire && req_ch.kind == KIND_START) |=> query_empty_ff)
      else $error("empty flag cleared without a start point");

   a_frozen_interval: assert property (@(posedge clock) disable iff (reset)
      req_fire && req_ch.kind == KIND_PLANE && query_empty_ff
      |=> $stable(t_enter_ff) && $stable(t_exit_ff))
      else $error("plane changed the interval of an empty query");

   a_div_nonzero: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_WAIT |-> acc_den_ff != '0)
      else $error("division started with zero denominator");

endmodule

`default_nettype wire

### verif/segment_polyhedron_clip_test.sv
// ----------------------------------------------------------------------------
// segment_polyhedron_clip_test: self-checking bench for the segment clipper
// Streams start points, end points, clipping planes and no-ops into the
// request channel with bursty traffic and a stalling response side. Every
// accepted request updates a cycle-free model of the Cyrus-Beck interval,
// and each response is checked field by field against the oldest prediction.
// ----------------------------------------------------------------------------
`default_nettype none

module segment_polyhedron_clip_test;
   import spc_pkg::*;

   timeunit 1ns;
   timeprecision 1ps;

   // kind code that the package leaves unnamed: changes nothing
   localparam logic [KIND_W-1:0] KIND_NOP = 2'd3;

   localparam logic signed [FIELD_W-1:0] C_MIN = 32'h8000_0000;
   localparam logic signed [FIELD_W-1:0] C_MAX = 32'h7fff_ffff;
   localparam logic signed [FIELD_W-1:0] Q_ONE = 32'h0001_0000;

   localparam int ITEM_TARGET = 1550;
   localparam int QUEUE_DEPTH = 16;
   // planes are slow to process; allow for gaps, stalls and slack
   localparam int CYCLE_LIMIT = 1_500_000;
   localparam int TAIL_CYCLES = 300;

   typedef struct {
      logic [KIND_W-1:0]         kind;
      logic signed [FIELD_W-1:0] x;
      logic signed [FIELD_W-1:0] y;
      logic signed [FIELD_W-1:0] z;
      logic signed [FIELD_W-1:0] offset;
      logic                      last;
   } clip_request_type;

   typedef struct {
      logic                  hit;
      logic signed [T_W-1:0] t_first;
      logic signed [T_W-1:0] t_last;
   } clip_result_type;

   logic clock;
   logic reset;

   spc_req_if req_ch ();
   spc_rsp_if rsp_ch ();

   segment_polyhedron_clip dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch)
   );

   clip_request_type pending_requests[$];
   clip_result_type  expected_clips[$];

   int error_count  = 0;
   int useful_count = 0;
   int cycle_count  = 0;

   // driver pacing
   int   burst_left = 1;
   int   gap_left   = 0;
   logic req_taken  = 1'b0;

   // receiver stall pattern
   logic [31:0] ready_pattern = '1;
   int          pattern_phase = 0;

   // model of the clipper state
   logic signed [IN_BITS-1:0] seg_origin[AXES];
   logic signed [DIR_W-1:0]   seg_span[AXES];
   logic signed [T_W-1:0]     entry_t;
   logic signed [T_W-1:0]     exit_t;
   logic                      clipped_away;

   // ------------------------------------------------------------------------
   // Clock and reset
   // ------------------------------------------------------------------------
   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      reset = 1'b1;
      req_ch.valid  = 1'b0;
      req_ch.kind   = '0;
      req_ch.x      = '0;
      req_ch.y      = '0;
      req_ch.z      = '0;
      req_ch.offset = '0;
      req_ch.last   = 1'b0;
      rsp_ch.ready  = 1'b0;
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
   end

   // ------------------------------------------------------------------------
   // Model: sign-extend a field from the coordinate width
   // ------------------------------------------------------------------------
   function automatic logic signed [127:0] coord_wide(input logic [FIELD_W-1:0] v);
      logic signed [IN_BITS-1:0] narrow;
      narrow = v[IN_BITS-1:0];
      return narrow;
   endfunction

   // Apply one accepted request to the model; report the response it causes.
   task automatic clip_predict(input clip_request_type rq, output logic emits,
                               output clip_result_type res);
      logic signed [FIELD_W-1:0] comp[AXES];
      logic signed [127:0]       nrm, origin_w, span_w, denom, dist_w, diff;
      logic [159:0]              num_mag, den_mag, quo;
      logic signed [T_W-1:0]     t;
      comp[0] = rq.x;
      comp[1] = rq.y;
      comp[2] = rq.z;
      case (rq.kind)
         KIND_START: begin
            for (int i = 0; i < AXES; i++) begin
               seg_origin[i] = comp[i][IN_BITS-1:0];
               seg_span[i]   = '0;
            end
            entry_t      = '0;
            exit_t       = T_ONE;
            clipped_away = 1'b0;
         end
         KIND_END: begin
            for (int i = 0; i < AXES; i++) begin
               origin_w    = seg_origin[i];
               diff        = coord_wide(comp[i]) - origin_w;
               seg_span[i] = diff[DIR_W-1:0];
            end
         end
         KIND_PLANE: begin
            if (!clipped_away) begin
               denom  = '0;
               dist_w = coord_wide(rq.offset) <<< COORD_FRAC;
               for (int i = 0; i < AXES; i++) begin
                  nrm      = coord_wide(comp[i]);
                  origin_w = seg_origin[i];
                  span_w   = seg_span[i];
                  denom    = denom + nrm * span_w;
                  dist_w   = dist_w - nrm * origin_w;
               end
               if (denom == 0) begin
                  // parallel plane: outside when the offset is beyond the start
                  if (dist_w > 0)
                     clipped_away = 1'b1;
               end else begin
                  num_mag = '0;
                  den_mag = '0;
                  num_mag[127:0] = dist_w[127] ? -dist_w : dist_w;
                  den_mag[127:0] = denom[127] ? -denom : denom;
                  quo = (num_mag << T_FRAC_BITS) / den_mag;
                  if (dist_w[127] != denom[127])
                     t = (quo >= 160'h8000_0000) ? T_MIN : -signed'(quo[T_W-1:0]);
                  else
                     t = (quo > 160'h7fff_ffff) ? T_MAX : signed'(quo[T_W-1:0]);
                  if (denom[127]) begin
                     if (t > entry_t)
                        entry_t = t;
                  end else begin
                     if (t < exit_t)
                        exit_t = t;
                  end
                  if (entry_t > exit_t)
                     clipped_away = 1'b1;
               end
            end
         end
         default: begin
         end
      endcase
      emits       = rq.last;
      res.hit     = !clipped_away;
      res.t_first = entry_t;
      res.t_last  = exit_t;
   endtask

   // ------------------------------------------------------------------------
   // Stimulus helpers
   // ------------------------------------------------------------------------
   task automatic queue_request(input logic [KIND_W-1:0] kind,
                                input logic signed [FIELD_W-1:0] x, y, z, offset,
                                input logic last);
      clip_request_type rq;
      rq.kind   = kind;
      rq.x      = x;
      rq.y      = y;
      rq.z      = z;
      rq.offset = offset;
      rq.last   = last;
      pending_requests.push_back(rq);
   endtask

   function automatic logic signed [FIELD_W-1:0] pick_extreme();
      case ($urandom_range(0, 3))
         0:       return C_MIN;
         1:       return C_MAX;
         2:       return '0;
         default: return -1;
      endcase
   endfunction

   // points: mostly inside a +-16.0 box so that planes clip in [0,1]
   function automatic logic signed [FIELD_W-1:0] pick_coord();
      case ($urandom_range(0, 7))
         0:       return $urandom;
         1:       return pick_extreme();
         default: return int'($urandom_range(0, 32 << 16)) - (16 << 16);
      endcase
   endfunction

   function automatic logic signed [FIELD_W-1:0] pick_normal();
      case ($urandom_range(0, 9))
         0:       return $urandom;
         1:       return pick_extreme();
         2, 3:    return '0;
         default: return int'($urandom_range(0, 8 << 16)) - (4 << 16);
      endcase
   endfunction

   function automatic logic signed [FIELD_W-1:0] pick_offset();
      case ($urandom_range(0, 7))
         0:       return $urandom;
         1:       return pick_extreme();
         default: return int'($urandom_range(0, 128 << 16)) - (64 << 16);
      endcase
   endfunction

   // ------------------------------------------------------------------------
   // Stimulus and end of run
   // ------------------------------------------------------------------------
   initial begin
      int nplanes;
      // --- directed part ---
      // no-op on reset state
      queue_request(KIND_NOP, '0, '0, '0, '0, 1'b1);
      // segment along x from 0 to 10; entry at 0.2, exit at 0.7
      queue_request(KIND_START, '0, '0, '0, '0, 1'b0);
      queue_request(KIND_END, 10 * Q_ONE, '0, '0, '0, 1'b0);
      queue_request(KIND_PLANE, -Q_ONE, '0, '0, -2 * Q_ONE, 1'b0);
      queue_request(KIND_PLANE, Q_ONE, '0, '0, 7 * Q_ONE, 1'b1);
      // parallel planes: on the boundary, inside, then outside
      queue_request(KIND_PLANE, '0, Q_ONE, '0, '0, 1'b1);
      queue_request(KIND_PLANE, '0, Q_ONE, '0, -Q_ONE, 1'b0);
      queue_request(KIND_PLANE, '0, Q_ONE, '0, Q_ONE, 1'b1);
      // plane on an empty query: ignored, interval frozen
      queue_request(KIND_PLANE, Q_ONE, '0, '0, '0, 1'b1);
      // extreme coordinates, normals and offsets
      queue_request(KIND_START, C_MAX, C_MIN, C_MAX, C_MIN, 1'b1);
      queue_request(KIND_END, C_MIN, C_MAX, C_MIN, C_MAX, 1'b1);
      queue_request(KIND_PLANE, C_MIN, C_MIN, C_MIN, C_MAX, 1'b0);
      queue_request(KIND_PLANE, C_MAX, C_MAX, C_MAX, C_MIN, 1'b1);
      // tiny direction: quotient saturates high, low, then empties the query
      queue_request(KIND_START, '0, '0, '0, '0, 1'b0);
      queue_request(KIND_END, 32'sd1, '0, '0, '0, 1'b0);
      queue_request(KIND_PLANE, Q_ONE, '0, '0, C_MAX, 1'b0);
      queue_request(KIND_PLANE, -Q_ONE, '0, '0, C_MAX, 1'b0);
      queue_request(KIND_PLANE, -Q_ONE, '0, '0, C_MIN, 1'b1);
      // entry equals exit: still a hit
      queue_request(KIND_START, '0, '0, '0, '0, 1'b1);
      queue_request(KIND_END, 10 * Q_ONE, '0, '0, '0, 1'b0);
      queue_request(KIND_PLANE, -Q_ONE, '0, '0, -5 * Q_ONE, 1'b0);
      queue_request(KIND_PLANE, Q_ONE, '0, '0, 5 * Q_ONE, 1'b1);
      // degenerate segment (no end point) and a silent no-op
      queue_request(KIND_START, Q_ONE, Q_ONE, Q_ONE, '0, 1'b0);
      queue_request(KIND_NOP, $urandom, $urandom, $urandom, $urandom, 1'b0);
      queue_request(KIND_PLANE, '0, '0, Q_ONE, '0, 1'b1);

      // --- random part ---
      while (useful_count < ITEM_TARGET) begin
         while (pending_requests.size() >= QUEUE_DEPTH)
            @(posedge clock);
         case ($urandom_range(0, 9))
            8: begin
               // noise: any kind, any content
               repeat ($urandom_range(1, 4))
                  queue_request(KIND_W'($urandom), $urandom, $urandom, $urandom,
                                $urandom, 1'($urandom));
            end
            9: begin
               // more planes onto whatever query is open
               nplanes = $urandom_range(1, 3);
               for (int i = 0; i < nplanes; i++)
                  queue_request(KIND_PLANE, pick_normal(), pick_normal(), pick_normal(),
                                pick_offset(), i == nplanes - 1);
            end
            default: begin
               // well-formed query
               queue_request(KIND_START, pick_coord(), pick_coord(), pick_coord(),
                             $urandom, $urandom_range(0, 15) == 0);
               queue_request(KIND_END, pick_coord(), pick_coord(), pick_coord(),
                             $urandom, $urandom_range(0, 15) == 0);
               nplanes = $urandom_range(1, 6);
               for (int i = 0; i < nplanes; i++)
                  queue_request(KIND_PLANE, pick_normal(), pick_normal(), pick_normal(),
                                pick_offset(), i == nplanes - 1);
               if ($urandom_range(0, 7) == 0)
                  queue_request(KIND_NOP, $urandom, $urandom, $urandom, $urandom, 1'b1);
            end
         endcase
      end

      // drain: all requests taken, all responses back, then a quiet tail
      while (pending_requests.size() != 0 || req_ch.valid)
         @(posedge clock);
      while (expected_clips.size() != 0)
         @(posedge clock);
      repeat (TAIL_CYCLES) @(posedge clock);
      if (error_count == 0)
         $display("Testbench completed without errors");
      else
         $display("Testbench completed WITH ERRORS");
      $finish;
   end

   // ------------------------------------------------------------------------
   // Driver: change inputs on the falling edge, in bursts with gaps
   // ------------------------------------------------------------------------
   always @(negedge clock) begin
      clip_request_type rq;
      logic             next_valid;
      if (!reset) begin
         // hold the request until the block takes it
         if (!(req_ch.valid && !req_taken)) begin
            next_valid = 1'b0;
            if (gap_left != 0) begin
               gap_left <= gap_left - 1;
            end else if (pending_requests.size() != 0) begin
               rq = pending_requests.pop_front();
               req_ch.kind   <= rq.kind;
               req_ch.x      <= rq.x;
               req_ch.y      <= rq.y;
               req_ch.z      <= rq.z;
               req_ch.offset <= rq.offset;
               req_ch.last   <= rq.last;
               next_valid = 1'b1;
               if (burst_left <= 1) begin
                  // close the burst: pick the next length and the gap before it
                  burst_left <= ($urandom_range(0, 7) == 0) ? $urandom_range(100, 300)
                                                            : $urandom_range(1, 24);
                  gap_left   <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 15);
               end else begin
                  burst_left <= burst_left - 1;
               end
            end
            req_ch.valid <= next_valid;
         end
      end
   end

   // Receiver: advance through a 32-bit ready pattern, redrawn each lap
   always @(negedge clock) begin
      rsp_ch.ready <= ready_pattern[pattern_phase];
      if (pattern_phase == 31) begin
         pattern_phase <= 0;
         case ($urandom_range(0, 3))
            0:       ready_pattern <= '1;
            1:       ready_pattern <= $urandom;
            2:       ready_pattern <= $urandom & $urandom & $urandom;
            default: ready_pattern <= $urandom | $urandom;
         endcase
      end else begin
         pattern_phase <= pattern_phase + 1;
      end
   end

   // ------------------------------------------------------------------------
   // Monitor: sample both channels on the rising edge
   // ------------------------------------------------------------------------
   always @(posedge clock) begin
      clip_request_type rq;
      clip_result_type  want;
      clip_result_type  res;
      logic             emits;
      if (reset) begin
         req_taken <= 1'b0;
         seg_origin   = '{default: '0};
         seg_span     = '{default: '0};
         entry_t      = '0;
         exit_t       = T_ONE;
         clipped_away = 1'b0;
      end else begin
         req_taken <= req_ch.valid && req_ch.ready;

         // check a response against the oldest prediction
         if (rsp_ch.valid && rsp_ch.ready) begin
            if (expected_clips.size() == 0) begin
               $error("response with none expected: hit=%0d t_first=%0d t_last=%0d",
                      rsp_ch.hit, rsp_ch.t_first, rsp_ch.t_last);
               error_count++;
            end else begin
               want = expected_clips.pop_front();
               if (rsp_ch.hit !== want.hit) begin
                  $error("hit mismatch: expected %0d, got %0d", want.hit, rsp_ch.hit);
                  error_count++;
               end
               if (rsp_ch.t_first !== want.t_first) begin
                  $error("t_first mismatch: expected %0d, got %0d",
                         want.t_first, rsp_ch.t_first);
                  error_count++;
               end
               if (rsp_ch.t_last !== want.t_last) begin
                  $error("t_last mismatch: expected %0d, got %0d",
                         want.t_last, rsp_ch.t_last);
                  error_count++;
               end
            end
         end

         // advance the model on each accepted request
         if (req_ch.valid && req_ch.ready) begin
            rq.kind   = req_ch.kind;
            rq.x      = req_ch.x;
            rq.y      = req_ch.y;
            rq.z      = req_ch.z;
            rq.offset = req_ch.offset;
            rq.last   = req_ch.last;
            clip_predict(rq, emits, res);
            if (emits)
               expected_clips.push_back(res);
            useful_count++;
         end
      end
   end

   // Watchdog
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("Testbench completed WITH ERRORS");
         $finish;
      end
   end

endmodule

`default_nettype wire

### sim.f
rtl/spc_pkg.sv
rtl/spc_channels.sv
rtl/spc_div.sv
rtl/segment_polyhedron_clip.sv
verif/segment_polyhedron_clip_test.sv
